// ===== hw/rtl/svpwm_pkg.sv =====
// Shared constants, types and tables for the space vector PWM duty generator.
// Used by the CORDIC and divider cells, by the top level and by the testbench.
// Depends on nothing.
`default_nettype none

package svpwm_pkg;

  typedef logic [31:0] turn_t;

  // Angle and mode flags that travel with an item through the arctangent chain.
  typedef struct packed {
    turn_t theta;
    logic  d_zero;
    logic  q_neg;
  } at_side_t;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int VOLT_BITS_DEF  = 16;
  localparam int CORDIC_STEPS   = 24;
  localparam int MOD_W          = 16;
  localparam int DIV_STEPS      = MOD_W;
  localparam int ROT_W          = 34;
  localparam int PADDR_W        = 3;

  localparam int              SUPPLY_RESET = 3072;
  localparam logic [15:0]     PERIOD_RESET = 16'd5000;
  localparam logic [MOD_W-1:0] MOD_CLAMP   = 16'd37814;

  localparam logic REG_SUPPLY = 1'b0;
  localparam logic REG_PERIOD = 1'b1;

  localparam logic signed [ROT_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [63:0] HALF_SQRT3_Q30 = 64'sd929887697;
  localparam logic signed [63:0] SQRT3_Q30      = 64'sd1859775393;
  localparam logic signed [63:0] ONE_Q30        = 64'sd1073741824;

  localparam turn_t QUARTER_TURN       = 32'h4000_0000;
  localparam turn_t HALF_TURN          = 32'h8000_0000;
  localparam turn_t THREE_QUARTER_TURN = 32'hC000_0000;

  localparam logic [2:0] SECT_0 = 3'd0;
  localparam logic [2:0] SECT_1 = 3'd1;
  localparam logic [2:0] SECT_2 = 3'd2;
  localparam logic [2:0] SECT_3 = 3'd3;
  localparam logic [2:0] SECT_4 = 3'd4;
  localparam logic [2:0] SECT_5 = 3'd5;

  // Arctangent of 2^-step as a fraction of a turn, 2^32 counts per turn.
  function automatic turn_t atan_turn(input int step);
    case (step)
      0:  return 32'd536870912;
      1:  return 32'd316933406;
      2:  return 32'd167458907;
      3:  return 32'd85004757;
      4:  return 32'd42667331;
      5:  return 32'd21354465;
      6:  return 32'd10679838;
      7:  return 32'd5340245;
      8:  return 32'd2670163;
      9:  return 32'd1335087;
      10: return 32'd667544;
      11: return 32'd333772;
      12: return 32'd166886;
      13: return 32'd83443;
      14: return 32'd41722;
      15: return 32'd20861;
      16: return 32'd10430;
      17: return 32'd5215;
      18: return 32'd2608;
      19: return 32'd1304;
      20: return 32'd652;
      21: return 32'd326;
      22: return 32'd163;
      23: return 32'd81;
      default: return '0;
    endcase
  endfunction

  // Start of each sector in turn counts, rounded up, so that the angle within
  // the sector is the floor of the sixfold remainder divided by six.
  function automatic turn_t sector_base(input logic [2:0] k);
    case (k)
      SECT_0:  return 32'd0;
      SECT_1:  return 32'd715827883;
      SECT_2:  return 32'd1431655766;
      SECT_3:  return 32'd2147483648;
      SECT_4:  return 32'd2863311531;
      SECT_5:  return 32'd3579139414;
      default: return 32'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/svpwm_duty_generator.sv =====
// Space vector PWM duty generator: dq voltage request and rotor angle to three
// timer compare values and a sector number. Top level of the pipeline.
// Depends on svpwm_pkg and the cordic, sqrt and div cells.
//
//   channel   direction  handshake            beat
//   input     in         in_valid / in_stall  q_voltage, d_voltage, electrical_angle
//   output    out        out_valid/out_stall  compare_a, compare_b, compare_c, sector_index
//   config    in         APB write / read     supply_voltage (0x0), pwm_period (0x4)
//
// One beat is taken per clock while in_stall is low. A beat passes the 24-cell
// arctangent chain followed by the 24-cell sine and cosine chain, plus the
// entry, sector and product stages.
// Reset is synchronous and clears only the valid bits and the two registers.
// While a result waits under out_stall the whole pipeline holds and in_stall
// is raised; it is released in the cycle the result is taken.
`default_nettype none

module svpwm_duty_generator #(
  parameter int ANGLE_BITS = svpwm_pkg::ANGLE_BITS_DEF,
  parameter int VOLT_BITS  = svpwm_pkg::VOLT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [svpwm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VOLT_BITS-1:0]   q_voltage,
  input  logic signed [VOLT_BITS-1:0]   d_voltage,
  input  logic [ANGLE_BITS-1:0]         electrical_angle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   compare_a,
  output logic [15:0]                   compare_b,
  output logic [15:0]                   compare_c,
  output logic [2:0]                    sector_index
);
  import svpwm_pkg::*;

  // Arctangent datapath width: the request scaled by 2^24 plus CORDIC growth.
  localparam int AW     = VOLT_BITS + 27;
  localparam int SQ_W   = 2 * VOLT_BITS;
  localparam int SUP_W  = (VOLT_BITS > 12) ? VOLT_BITS : 12;
  localparam int SIDE_W = $bits(at_side_t);
  localparam int CS     = CORDIC_STEPS;
  localparam int LAST   = 2 * CS + 8;
  // The modulation index must meet the angle data at the stage before the
  // multipliers; a short delay line makes up the difference.
  localparam int M_TGT  = 2 * CS + 4;
  localparam int M_DLY  = M_TGT - (VOLT_BITS + DIV_STEPS);
  localparam int AB_W   = ROT_W + 2;
  localparam int TW     = 38;

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must change them only while the pipeline
  // is empty; the block does not enforce this. Every stage reads them directly.
  // ---------------------------------------------------------------------------
  logic [SUP_W-1:0] supply_voltage;
  logic [15:0]      pwm_period;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      supply_voltage <= SUP_W'(SUPPLY_RESET);
      pwm_period     <= PERIOD_RESET;
    end else if (cfg_wr) begin
      case (paddr[PADDR_W-1])
        REG_SUPPLY: supply_voltage <= SUP_W'(pwdata[VOLT_BITS-1:0]);
        REG_PERIOD: pwm_period     <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1])
      REG_SUPPLY: prdata = 32'(supply_voltage);
      REG_PERIOD: prdata = 32'(pwm_period);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: one enable for every stage, the last stage being the
  // output register.
  // ---------------------------------------------------------------------------
  logic          en;
  logic [LAST:0] vld;

  assign en        = ~(vld[LAST] & out_stall);
  assign in_stall  = ~en;
  assign out_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], in_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Entry stage: sum of squares for the magnitude, and the arctangent start
  // vector. A negative d is turned by half a turn first so the CORDIC only
  // sees the right half plane.
  // ---------------------------------------------------------------------------
  logic signed [SQ_W-1:0] q_sq;
  logic signed [SQ_W-1:0] d_sq;
  logic signed [AW-1:0]   q_ext;
  logic signed [AW-1:0]   d_ext;
  logic                   d_neg;
  at_side_t               side_new;

  logic [SQ_W-1:0]      sq_sum;
  logic signed [AW-1:0] at_x0;
  logic signed [AW-1:0] at_y0;
  turn_t                at_z0;
  at_side_t             at_side0;

  always_comb begin
    q_sq           = q_voltage * q_voltage;
    d_sq           = d_voltage * d_voltage;
    q_ext          = AW'(q_voltage);
    d_ext          = AW'(d_voltage);
    d_neg          = d_voltage[VOLT_BITS-1];
    side_new.theta = 32'(electrical_angle) << (32 - ANGLE_BITS);
    side_new.d_zero = (d_voltage == '0);
    side_new.q_neg = q_voltage[VOLT_BITS-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_sum   <= $unsigned(q_sq) + $unsigned(d_sq);
      at_x0    <= (d_neg ? -d_ext : d_ext) <<< 24;
      at_y0    <= (d_neg ? -q_ext : q_ext) <<< 24;
      at_z0    <= d_neg ? HALF_TURN : '0;
      at_side0 <= side_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Magnitude: square root cells, then divider cells for |V| * 2^16 / supply.
  // A magnitude at or above the supply gives a quotient of at least one, which
  // is past the clamp, so only sixteen quotient bits are formed.
  // ---------------------------------------------------------------------------
  logic [SQ_W-1:0]      sq_v    [0:VOLT_BITS];
  logic [VOLT_BITS-1:0] sq_root [0:VOLT_BITS];
  logic [VOLT_BITS+2:0] sq_rem  [0:VOLT_BITS];

  assign sq_v[0]    = sq_sum;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;

  for (genvar i = 0; i < VOLT_BITS; i++) begin : g_sqrt
    svpwm_sqrt_cell #(
      .VW(VOLT_BITS)
    ) u_cell (
      .clk     (clk),
      .en      (en),
      .v_in    (sq_v[i]),
      .root_in (sq_root[i]),
      .rem_in  (sq_rem[i]),
      .v_out   (sq_v[i+1]),
      .root_out(sq_root[i+1]),
      .rem_out (sq_rem[i+1])
    );
  end

  logic [SUP_W-1:0] mag;
  logic [SUP_W:0]   dv_rem [0:DIV_STEPS];
  logic [MOD_W-1:0] dv_quo [0:DIV_STEPS];
  logic             dv_ovf [0:DIV_STEPS];

  assign mag       = SUP_W'(sq_root[VOLT_BITS]);
  assign dv_rem[0] = {1'b0, mag};
  assign dv_quo[0] = '0;
  assign dv_ovf[0] = (mag >= supply_voltage);

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    svpwm_div_cell #(
      .DW(SUP_W)
    ) u_cell (
      .clk    (clk),
      .en     (en),
      .dvsr   (supply_voltage),
      .rem_in (dv_rem[i]),
      .quo_in (dv_quo[i]),
      .ovf_in (dv_ovf[i]),
      .rem_out(dv_rem[i+1]),
      .quo_out(dv_quo[i+1]),
      .ovf_out(dv_ovf[i+1])
    );
  end

  logic [MOD_W-1:0] m_first;
  logic [MOD_W-1:0] m_dly [0:M_DLY-1];
  logic [MOD_W-1:0] m_stage;

  always_comb begin
    if (dv_ovf[DIV_STEPS] || (dv_quo[DIV_STEPS] > MOD_CLAMP)) begin
      m_first = MOD_CLAMP;
    end else begin
      m_first = dv_quo[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_dly[0] <= m_first;
      for (int j = 1; j < M_DLY; j++) begin
        m_dly[j] <= m_dly[j-1];
      end
    end
  end

  assign m_stage = m_dly[M_DLY-1];

  // ---------------------------------------------------------------------------
  // Arctangent of q over d, vectoring CORDIC.
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0] at_x    [0:CS];
  logic signed [AW-1:0] at_y    [0:CS];
  turn_t                at_z    [0:CS];
  logic [SIDE_W-1:0]    at_side [0:CS];

  assign at_x[0]    = at_x0;
  assign at_y[0]    = at_y0;
  assign at_z[0]    = at_z0;
  assign at_side[0] = at_side0;

  for (genvar i = 0; i < CS; i++) begin : g_atan
    svpwm_cordic_cell #(
      .W        (AW),
      .ZW       (32),
      .STEP     (i),
      .VECTORING(1'b1),
      .SIDE_W   (SIDE_W)
    ) u_cell (
      .clk     (clk),
      .en      (en),
      .x_in    (at_x[i]),
      .y_in    (at_y[i]),
      .z_in    (at_z[i]),
      .side_in (at_side[i]),
      .x_out   (at_x[i+1]),
      .y_out   (at_y[i+1]),
      .z_out   (at_z[i+1]),
      .side_out(at_side[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Total angle, then sector and angle within the sector. With d zero the
  // vector points along q, a quarter or three quarters of a turn.
  // ---------------------------------------------------------------------------
  at_side_t   at_end;
  turn_t      theta_tot;
  logic [34:0] prod6;
  logic [2:0]  k_new;

  logic [ROT_W-1:0] rot_z0;
  logic [2:0]       rot_k0;

  assign at_end = at_side_t'(at_side[CS]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (at_end.d_zero) begin
        theta_tot <= at_end.theta + (at_end.q_neg ? THREE_QUARTER_TURN : QUARTER_TURN);
      end else begin
        theta_tot <= at_end.theta + at_z[CS];
      end
    end
  end

  always_comb begin
    prod6 = {1'b0, theta_tot, 2'b00} + {2'b00, theta_tot, 1'b0};
    k_new = prod6[34:32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_z0 <= {2'b00, theta_tot - sector_base(k_new)};
      rot_k0 <= k_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Cosine and sine of the in-sector angle, rotation CORDIC in Q4.30.
  // ---------------------------------------------------------------------------
  logic signed [ROT_W-1:0] rot_x [0:CS];
  logic signed [ROT_W-1:0] rot_y [0:CS];
  logic [ROT_W-1:0]        rot_z [0:CS];
  logic [2:0]              rot_k [0:CS];

  assign rot_x[0] = CORDIC_GAIN_Q30;
  assign rot_y[0] = '0;
  assign rot_z[0] = rot_z0;
  assign rot_k[0] = rot_k0;

  for (genvar i = 0; i < CS; i++) begin : g_rot
    svpwm_cordic_cell #(
      .W        (ROT_W),
      .ZW       (ROT_W),
      .STEP     (i),
      .VECTORING(1'b0),
      .SIDE_W   (3)
    ) u_cell (
      .clk     (clk),
      .en      (en),
      .x_in    (rot_x[i]),
      .y_in    (rot_y[i]),
      .z_in    (rot_z[i]),
      .side_in (rot_k[i]),
      .x_out   (rot_x[i+1]),
      .y_out   (rot_y[i+1]),
      .z_out   (rot_z[i+1]),
      .side_out(rot_k[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Dwell times. First the constant products and 3c, then the two terms of
  // T1 and T2 before scaling by the modulation index.
  // ---------------------------------------------------------------------------
  logic signed [63:0]     hs;
  logic signed [63:0]     s3s;
  logic signed [AB_W-1:0] c3;
  logic [2:0]             k1;

  always_ff @(posedge clk) begin
    if (en) begin
      hs  <= 64'(rot_y[CS]) * HALF_SQRT3_Q30;
      s3s <= 64'(rot_y[CS]) * SQRT3_Q30;
      c3  <= AB_W'(rot_x[CS]) + (AB_W'(rot_x[CS]) <<< 1);
      k1  <= rot_k[CS];
    end
  end

  // 3c/2 rounds towards zero, so a negative value is nudged up by one first.
  logic signed [AB_W-1:0] c3_adj;
  logic signed [AB_W-1:0] term_a;
  logic signed [AB_W-1:0] term_b;
  logic [2:0]             k2;

  assign c3_adj = c3 + $signed({{(AB_W-1){1'b0}}, c3[AB_W-1]});

  always_ff @(posedge clk) begin
    if (en) begin
      term_a <= (c3_adj >>> 1) - AB_W'(hs >>> 30);
      term_b <= AB_W'(s3s >>> 30);
      k2     <= k1;
    end
  end

  logic signed [AB_W+16:0] t1p;
  logic signed [AB_W+16:0] t2p;
  logic [2:0]              k3;

  always_ff @(posedge clk) begin
    if (en) begin
      t1p <= $signed({1'b0, m_stage}) * term_a;
      t2p <= $signed({1'b0, m_stage}) * term_b;
      k3  <= k2;
    end
  end

  logic signed [TW-1:0] t1_w;
  logic signed [TW-1:0] t2_w;
  logic signed [TW-1:0] t12_w;
  logic signed [TW-1:0] t1;
  logic signed [TW-1:0] t2;
  logic signed [TW-1:0] t12;
  logic signed [TW-1:0] half0;
  logic [2:0]           k4;

  always_comb begin
    t1_w  = TW'(t1p >>> 16);
    t2_w  = TW'(t2p >>> 16);
    t12_w = t1_w + t2_w;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1    <= t1_w;
      t2    <= t2_w;
      t12   <= t12_w;
      half0 <= (TW'(ONE_Q30) - t12_w) >>> 1;
      k4    <= k3;
    end
  end

  // ---------------------------------------------------------------------------
  // Six-sector duty table and clamp to [0, 1].
  // ---------------------------------------------------------------------------
  function automatic logic [30:0] clamp_duty(input logic signed [TW-1:0] v);
    if (v[TW-1]) begin
      return '0;
    end else if (v > TW'(ONE_Q30)) begin
      return 31'(ONE_Q30);
    end else begin
      return v[30:0];
    end
  endfunction

  logic signed [TW-1:0] ta;
  logic signed [TW-1:0] tb;
  logic signed [TW-1:0] tc;
  logic [30:0]          duty_a;
  logic [30:0]          duty_b;
  logic [30:0]          duty_c;
  logic [2:0]           k5;

  always_comb begin
    case (k4)
      SECT_0: begin
        ta = t12 + half0;
        tb = t2 + half0;
        tc = half0;
      end
      SECT_1: begin
        ta = t1 + half0;
        tb = t12 + half0;
        tc = half0;
      end
      SECT_2: begin
        ta = half0;
        tb = t12 + half0;
        tc = t2 + half0;
      end
      SECT_3: begin
        ta = half0;
        tb = t1 + half0;
        tc = t12 + half0;
      end
      SECT_4: begin
        ta = t2 + half0;
        tb = half0;
        tc = t12 + half0;
      end
      default: begin
        ta = t12 + half0;
        tb = half0;
        tc = t1 + half0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      duty_a <= clamp_duty(ta);
      duty_b <= clamp_duty(tb);
      duty_c <= clamp_duty(tc);
      k5     <= k4;
    end
  end

  // ---------------------------------------------------------------------------
  // Scale by the PWM period, truncating; this is the output register.
  // ---------------------------------------------------------------------------
  logic [46:0] pa;
  logic [46:0] pb;
  logic [46:0] pc;

  always_comb begin
    pa = 47'(duty_a) * 47'(pwm_period);
    pb = 47'(duty_b) * 47'(pwm_period);
    pc = 47'(duty_c) * 47'(pwm_period);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      compare_a    <= pa[45:30];
      compare_b    <= pb[45:30];
      compare_c    <= pc[45:30];
      sector_index <= k5;
    end
  end

`ifndef SYNTHESIS
  // The sector number out of the sixfold product never reaches six or seven.
  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sector_index != 3'd6) && (sector_index != 3'd7))
    else $error("sector index out of range");

  // The modulation index meeting the dwell multipliers is always clamped.
  a_mod_clamped: assert property (@(posedge clk) disable iff (rst)
    vld[M_TGT] |-> (m_stage <= MOD_CLAMP))
    else $error("modulation index above clamp");

  // Whenever the pipeline moves, the output valid follows the stage before it.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (!rst && !in_stall) |=> (out_valid == $past(vld[LAST-1])))
    else $error("pipeline advance lost or invented a beat");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/svpwm_cordic_cell.sv =====
// One CORDIC micro-rotation stage, vectoring or rotation mode, registered.
// Depends on svpwm_pkg for the arctangent table.
`default_nettype none

module svpwm_cordic_cell #(
  parameter int W         = 34,
  parameter int ZW        = 34,
  parameter int STEP      = 0,
  parameter bit VECTORING = 1'b0,
  parameter int SIDE_W    = 1
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  input  logic [ZW-1:0]       z_in,
  input  logic [SIDE_W-1:0]   side_in,
  output logic signed [W-1:0] x_out,
  output logic signed [W-1:0] y_out,
  output logic [ZW-1:0]       z_out,
  output logic [SIDE_W-1:0]   side_out
);
  import svpwm_pkg::*;

  localparam logic [ZW-1:0] ANGLE = ZW'(atan_turn(STEP));

  logic signed [W-1:0] xs;
  logic signed [W-1:0] ys;
  logic                plus;

  // Both modes share one update form; only the direction test differs.
  always_comb begin
    xs   = x_in >>> STEP;
    ys   = y_in >>> STEP;
    plus = VECTORING ? ~y_in[W-1] : z_in[ZW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (plus) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ANGLE;
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ANGLE;
      end
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/svpwm_sqrt_cell.sv =====
// One digit step of a non-restoring-free integer square root, two radicand
// bits per cell, registered. No package dependency.
`default_nettype none

module svpwm_sqrt_cell #(
  parameter int VW = 16
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*VW-1:0] v_in,
  input  logic [VW-1:0]   root_in,
  input  logic [VW+2:0]   rem_in,
  output logic [2*VW-1:0] v_out,
  output logic [VW-1:0]   root_out,
  output logic [VW+2:0]   rem_out
);

  localparam int RW = VW + 3;

  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          fit;

  always_comb begin
    rem_sh = {rem_in[RW-3:0], v_in[2*VW-1 -: 2]};
    trial  = RW'({root_in, 2'b01});
    fit    = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_out    <= {v_in[2*VW-3:0], 2'b00};
      rem_out  <= fit ? rem_sh - trial : rem_sh;
      root_out <= {root_in[VW-2:0], fit};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/svpwm_div_cell.sv =====
// One quotient bit of a restoring divider, registered, carrying an
// overflow flag. Depends on svpwm_pkg for the quotient width.
`default_nettype none

module svpwm_div_cell #(
  parameter int DW = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [DW-1:0]               dvsr,
  input  logic [DW:0]                 rem_in,
  input  logic [svpwm_pkg::MOD_W-1:0] quo_in,
  input  logic                        ovf_in,
  output logic [DW:0]                 rem_out,
  output logic [svpwm_pkg::MOD_W-1:0] quo_out,
  output logic                        ovf_out
);
  import svpwm_pkg::*;

  logic [DW:0] rem_sh;
  logic        fit;

  always_comb begin
    rem_sh = {rem_in[DW-1:0], 1'b0};
    fit    = rem_sh >= {1'b0, dvsr};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= fit ? rem_sh - {1'b0, dvsr} : rem_sh;
      quo_out <= {quo_in[MOD_W-2:0], fit};
      ovf_out <= ovf_in;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_svpwm_duty_generator.sv =====
// Self-checking testbench for the space vector PWM duty generator.
// Drives dq requests and angles, predicts every beat in fixed point and checks results.
// Depends on svpwm_pkg and the svpwm_duty_generator RTL.
`timescale 1ns / 100ps

module tb_svpwm_duty_generator;
  import svpwm_pkg::*;

  typedef struct {
    logic [15:0] cmp_a;
    logic [15:0] cmp_b;
    logic [15:0] cmp_c;
    logic [2:0]  sector;
  } duty_t;

  localparam int LATENCY = 57;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic signed [15:0] q_voltage = '0, d_voltage = '0;
  logic [15:0] electrical_angle = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] compare_a, compare_b, compare_c;
  logic [2:0]  sector_index;

  // The predictor's own copy of the two registers.
  logic [15:0] bus_volts = 16'd3072;
  logic [15:0] period_counts = 16'd5000;

  duty_t expected_duties[$];
  int    mismatches = 0;
  int    beats_sent = 0;
  int    beats_checked = 0;
  int    cycles = 0;
  // When set, both sides run flat out with no idle cycles.
  bit    no_idle = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  svpwm_duty_generator u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .q_voltage, .d_voltage, .electrical_angle,
    .out_valid, .out_stall, .compare_a, .compare_b, .compare_c, .sector_index
  );

  // Arithmetic shift right that floors, on 64-bit signed values.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitpos;
    root = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > v) bitpos >>= 2;
    while (bitpos != 0) begin
      if (v >= root + bitpos) begin
        v -= root + bitpos;
        root = (root >> 1) + bitpos;
      end else begin
        root >>= 1;
      end
      bitpos >>= 2;
    end
    return root;
  endfunction

  // Vectoring CORDIC: angle of (d, q) as a turn fraction.
  function automatic logic [31:0] vector_angle(longint y, longint x);
    logic [31:0] z;
    longint nx, ny;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    x = x * (64'sd1 << 24);
    y = y * (64'sd1 << 24);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + floor_shift(y, i);
        ny = y - floor_shift(x, i);
        z += atan_turn(i);
      end else begin
        nx = x - floor_shift(y, i);
        ny = y + floor_shift(x, i);
        z -= atan_turn(i);
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic logic [15:0] duty_to_compare(longint duty);
    longint unsigned prod;
    if (duty < 0) duty = 0;
    if (duty > ONE_Q30) duty = ONE_Q30;
    prod = longint'(unsigned'(duty)) * longint'(period_counts);
    return prod[45:30];
  endfunction

  function automatic duty_t svpwm_duties(logic signed [15:0] qv, logic signed [15:0] dv,
                                         logic [15:0] ang);
    duty_t res;
    longint q, d, r, x, y, nx, ny, a, t1, t2, t0, h, ta, tb, tc;
    longint unsigned mag, m, prod;
    logic [31:0] theta;
    logic [2:0] k;
    q = qv;
    d = dv;
    theta = {ang, 16'h0000};
    mag = int_sqrt(longint'(q * q + d * d));
    if (bus_volts == 0) begin
      m = MOD_CLAMP;
    end else begin
      m = (mag << 16) / bus_volts;
      if (m > MOD_CLAMP) m = MOD_CLAMP;
    end
    if (d != 0) theta += vector_angle(q, d);
    else theta += (q < 0) ? THREE_QUARTER_TURN : QUARTER_TURN;
    prod = longint'(theta) * 6;
    k = prod[34:32];
    r = longint'(prod[31:0] / 6);
    x = CORDIC_GAIN_Q30;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (r >= 0) begin
        nx = x - floor_shift(y, i);
        ny = y + floor_shift(x, i);
        r -= longint'(atan_turn(i));
      end else begin
        nx = x + floor_shift(y, i);
        ny = y - floor_shift(x, i);
        r += longint'(atan_turn(i));
      end
      x = nx;
      y = ny;
    end
    // 3c/2 truncates towards zero, as C division does.
    a = (3 * x) / 2 - floor_shift(HALF_SQRT3_Q30 * y, 30);
    t1 = floor_shift(longint'(m) * a, 16);
    t2 = floor_shift(longint'(m) * floor_shift(SQRT3_Q30 * y, 30), 16);
    t0 = ONE_Q30 - t1 - t2;
    h = floor_shift(t0, 1);
    case (k)
      SECT_0:  begin ta = t1 + t2 + h; tb = t2 + h;      tc = h;           end
      SECT_1:  begin ta = t1 + h;      tb = t1 + t2 + h; tc = h;           end
      SECT_2:  begin ta = h;           tb = t1 + t2 + h; tc = t2 + h;      end
      SECT_3:  begin ta = h;           tb = t1 + h;      tc = t1 + t2 + h; end
      SECT_4:  begin ta = t2 + h;      tb = h;           tc = t1 + t2 + h; end
      default: begin ta = t1 + t2 + h; tb = h;           tc = t1 + h;      end
    endcase
    res.cmp_a = duty_to_compare(ta);
    res.cmp_b = duty_to_compare(tb);
    res.cmp_c = duty_to_compare(tc);
    res.sector = k;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // Sends one beat, with a random idle gap in front of it unless idling is off.
  // The valid stays high on return; the next beat replaces it, and an idle gap
  // or a drain takes it down.
  task automatic send_beat(input logic [15:0] qv, input logic [15:0] dv,
                           input logic [15:0] ang);
    while (!no_idle && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    q_voltage <= qv;
    d_voltage <= dv;
    electrical_angle <= ang;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_duties.push_back(svpwm_duties(qv, dv, ang));
    beats_sent++;
    @(negedge clk);
  endtask

  // Waits until every expected result has arrived, then lets the pipeline run empty.
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_duties.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[PADDR_W-1] == REG_SUPPLY) bus_volts = data[15:0];
    else period_counts = data[15:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_registers(input logic [15:0] volts, input logic [15:0] period);
    drain();
    apb_write(PADDR_W'({REG_SUPPLY, 2'b00}), {16'h0000, volts});
    apb_write(PADDR_W'({REG_PERIOD, 2'b00}), {16'h0000, period});
  endtask

  // Field extremes, both zero-d branches, the zero request and each sector.
  task automatic test_directed;
    send_beat(16'h0000, 16'h0000, 16'h0000);
    send_beat(16'h7FFF, 16'h0000, 16'h0000);
    send_beat(16'h8000, 16'h0000, 16'hFFFF);
    send_beat(16'h0000, 16'h7FFF, 16'h8000);
    send_beat(16'h0000, 16'h8000, 16'h4000);
    send_beat(16'h8000, 16'h8000, 16'hC000);
    send_beat(16'h7FFF, 16'h7FFF, 16'h0001);
    send_beat(16'hFFFF, 16'h0001, 16'h5555);
    send_beat(16'h0100, 16'hFF00, 16'hAAAA);
    for (int s = 0; s < 6; s++) send_beat(16'h0000, 16'h0300, 16'((s * 65536) / 6 + 100));
    send_beat(16'h0080, 16'h0000, 16'h2AAA);
    send_beat(16'hFF80, 16'h0000, 16'h2AAB);
  endtask

  // Random requests over a spread of magnitudes, some with d exactly zero.
  task automatic test_random(input int count);
    logic [15:0] qv, dv;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: begin qv = 16'($urandom); dv = 16'($urandom); end
        1: begin qv = 16'($signed(10'($urandom))); dv = 16'($signed(10'($urandom))); end
        2: begin qv = 16'($urandom); dv = '0; end
        default: begin qv = 16'($signed(13'($urandom))); dv = 16'($signed(13'($urandom))); end
      endcase
      send_beat(qv, dv, 16'($urandom));
    end
  endtask

  // Back-to-back beats with both sides idling disabled.
  task automatic test_full_rate;
    no_idle = 1'b1;
    test_random(200);
    no_idle = 1'b0;
  endtask

  // The sender holds off until the pipeline is empty, then bursts again.
  task automatic test_pause_until_empty;
    test_random(30);
    in_valid <= 1'b0;
    while (expected_duties.size() != 0) @(negedge clk);
    test_random(30);
  endtask

  // Output side: random stall, and a result check at each accepted beat.
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !no_idle && ($urandom_range(99) < 22);
  end

  always @(posedge clk) begin
    duty_t want;
    cycles++;
    if (!rst && out_valid && !out_stall) begin
      if (expected_duties.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_duties.pop_front();
        beats_checked++;
        if (compare_a !== want.cmp_a)
          report_mismatch($sformatf("compare_a got %0d, expected %0d", compare_a, want.cmp_a));
        if (compare_b !== want.cmp_b)
          report_mismatch($sformatf("compare_b got %0d, expected %0d", compare_b, want.cmp_b));
        if (compare_c !== want.cmp_c)
          report_mismatch($sformatf("compare_c got %0d, expected %0d", compare_c, want.cmp_c));
        if (sector_index !== want.sector)
          report_mismatch($sformatf("sector_index got %0d, expected %0d",
                                    sector_index, want.sector));
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(350);
    set_registers(16'hFFFF, 16'hFFFF);
    test_directed();
    test_random(250);
    set_registers(16'h0001, 16'h0001);
    test_random(150);
    set_registers(16'h0000, 16'd1000);
    test_random(100);
    set_registers(16'h0C00, 16'd5000);
    test_full_rate();
    test_pause_until_empty();
    set_registers(16'h0400, 16'd20000);
    test_random(450);
    drain();
    if (expected_duties.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_duties.size()));
    $display("Covered %0d beats sent, %0d results checked, over five register settings.",
             beats_sent, beats_checked);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/svpwm_pkg.sv
hw/rtl/svpwm_cordic_cell.sv
hw/rtl/svpwm_sqrt_cell.sv
hw/rtl/svpwm_div_cell.sv
hw/rtl/svpwm_duty_generator.sv
test/tb_svpwm_duty_generator.sv
